FILE: sv/rdd_pkg.sv
// Package for the radial distance to planar depth block.
// Holds register codes, reset values, fixed widths and the config struct.
// No dependencies; used by rdd_front, rdd_sqrt, rdd_div and the top level.
`default_nettype none

package rdd_pkg;

  // Fixed widths of the arithmetic
  localparam int unsigned FOCAL_W    = 24;  // 1/f, unsigned Q0.24
  localparam int unsigned PRIN_W     = 16;  // principal point, Q12.4
  localparam int unsigned FRAC_BITS  = 20;  // fraction bits of u, v and the root
  localparam int unsigned PROD_SHIFT = 8;   // Q.4 * Q0.24 -> Q.20
  localparam int unsigned TERM_W     = 31;  // saturated |u|, |v|
  localparam int unsigned SQ_W       = 2 * TERM_W;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned SQ_STEPS   = 2;   // root bits per sqrt stage
  localparam int unsigned SQ_STAGES  = ROOT_W / SQ_STEPS;
  localparam int unsigned DIV_STEPS  = 2;   // quotient bits per divider stage

  localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
  localparam logic [SUM_W-1:0]  ONE_SQ   = SUM_W'(1) << (2 * FRAC_BITS);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = FOCAL_W;

  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y = 2'd3;

  localparam logic [FOCAL_W-1:0] RST_INV_FOCAL_X = 24'd34865;
  localparam logic [FOCAL_W-1:0] RST_INV_FOCAL_Y = 24'd34953;
  localparam logic [PRIN_W-1:0]  RST_PRINCIPAL_X = 16'd5112;
  localparam logic [PRIN_W-1:0]  RST_PRINCIPAL_Y = 16'd3832;

  typedef struct packed {
    logic [FOCAL_W-1:0] inv_focal_x;
    logic [FOCAL_W-1:0] inv_focal_y;
    logic [PRIN_W-1:0]  principal_x;
    logic [PRIN_W-1:0]  principal_y;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/rdd_front.sv
// Front stages: pixel offsets, scaled offsets, squares and sum of squares + 1.
// Four register stages, all advancing on en_i. Uses rdd_pkg.
`default_nettype none

module rdd_front #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DIST_BITS  = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  rdd_pkg::cfg_t                cfg_i,
  input  wire                          valid_i,
  input  wire  [DIST_BITS-1:0]         distance_i,
  input  wire  [COORD_BITS-1:0]        column_i,
  input  wire  [COORD_BITS-1:0]        row_i,
  output logic                         valid_o,
  output logic [rdd_pkg::SUM_W-1:0]    sum_o,
  output logic [DIST_BITS-1:0]         dist_o
);

  localparam int unsigned MAG_W  = (COORD_BITS + 4 > rdd_pkg::PRIN_W) ?
                                   COORD_BITS + 4 : rdd_pkg::PRIN_W;
  localparam int unsigned PROD_W = MAG_W + rdd_pkg::FOCAL_W;
  localparam int unsigned QT_W   = PROD_W - rdd_pkg::PROD_SHIFT;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_BITS-1:0] c,
                                                input logic [rdd_pkg::PRIN_W-1:0] p);
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    a = MAG_W'({c, 4'b0000});
    b = MAG_W'(p);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [rdd_pkg::TERM_W-1:0] scale_sat(input logic [PROD_W-1:0] prod);
    logic [QT_W-1:0] qt;
    qt = prod[PROD_W-1:rdd_pkg::PROD_SHIFT];
    return (|qt[QT_W-1:rdd_pkg::TERM_W]) ? rdd_pkg::TERM_MAX : qt[rdd_pkg::TERM_W-1:0];
  endfunction

  // stage A: offsets
  logic                 va_q;
  logic [MAG_W-1:0]     magx_q, magy_q;
  logic [DIST_BITS-1:0] dista_q;
  // stage B: |u|, |v| in Q.20
  logic                          vb_q;
  logic [rdd_pkg::TERM_W-1:0]    ux_q, uy_q;
  logic [DIST_BITS-1:0]          distb_q;
  // stage C: squares
  logic                          vc_q;
  logic [rdd_pkg::SQ_W-1:0]      sqx_q, sqy_q;
  logic [DIST_BITS-1:0]          distc_q;
  // stage D: sum
  logic                          vd_q;
  logic [rdd_pkg::SUM_W-1:0]     sum_q;
  logic [DIST_BITS-1:0]          distd_q;

  logic [PROD_W-1:0] prodx, prody;
  logic [rdd_pkg::SUM_W-1:0] sum_d;

  assign prodx = PROD_W'(magx_q) * PROD_W'(cfg_i.inv_focal_x);
  assign prody = PROD_W'(magy_q) * PROD_W'(cfg_i.inv_focal_y);
  assign sum_d = rdd_pkg::SUM_W'(sqx_q) + rdd_pkg::SUM_W'(sqy_q) + rdd_pkg::ONE_SQ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magx_q  <= abs_diff(column_i, cfg_i.principal_x);
      magy_q  <= abs_diff(row_i, cfg_i.principal_y);
      dista_q <= distance_i;
      ux_q    <= scale_sat(prodx);
      uy_q    <= scale_sat(prody);
      distb_q <= dista_q;
      sqx_q   <= rdd_pkg::SQ_W'(ux_q) * rdd_pkg::SQ_W'(ux_q);
      sqy_q   <= rdd_pkg::SQ_W'(uy_q) * rdd_pkg::SQ_W'(uy_q);
      distc_q <= distb_q;
      sum_q   <= sum_d;
      distd_q <= distc_q;
    end
  end

  assign valid_o = vd_q;
  assign sum_o   = sum_q;
  assign dist_o  = distd_q;

endmodule

`default_nettype wire

FILE: sv/rdd_sqrt.sv
// Pipelined integer square root, floor(sqrt(sum)), two root bits per stage.
// Carries the distance alongside. Uses rdd_pkg.
`default_nettype none

module rdd_sqrt #(
  parameter int unsigned DIST_BITS = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire  [rdd_pkg::SUM_W-1:0]    sum_i,
  input  wire  [DIST_BITS-1:0]         dist_i,
  output logic                         valid_o,
  output logic [rdd_pkg::ROOT_W-1:0]   root_o,
  output logic [DIST_BITS-1:0]         dist_o
);

  localparam int unsigned STAGES = rdd_pkg::SQ_STAGES;
  localparam int unsigned STEPS  = rdd_pkg::SQ_STEPS;
  localparam int unsigned ROOT_W = rdd_pkg::ROOT_W;
  localparam int unsigned SUM_W  = rdd_pkg::SUM_W;
  // partial remainder stays <= 2*root, so ROOT_W+1 bits, plus two shifted in
  localparam int unsigned REM_W  = ROOT_W + 3;

  logic                 v_q    [STAGES];
  logic [REM_W-1:0]     rem_q  [STAGES];
  logic [ROOT_W-1:0]    root_q [STAGES];
  logic [SUM_W-1:0]     op_q   [STAGES];
  logic [DIST_BITS-1:0] dist_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                 v_in;
    logic [REM_W-1:0]     rem_in, rem_d, trial;
    logic [ROOT_W-1:0]    root_in, root_d;
    logic [SUM_W-1:0]     op_in;
    logic [DIST_BITS-1:0] dist_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign op_in   = sum_i;
      assign dist_in = dist_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign op_in   = op_q[k-1];
      assign dist_in = dist_q[k-1];
    end

    always_comb begin
      rem_d  = rem_in;
      root_d = root_in;
      trial  = '0;
      for (int j = 0; j < STEPS; j++) begin
        rem_d = {rem_d[REM_W-3:0], op_in[SUM_W-1-2*(STEPS*k+j) -: 2]};
        trial = {1'b0, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        op_q[k]   <= op_in;
        dist_q[k] <= dist_in;
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign root_o  = root_q[STAGES-1];
  assign dist_o  = dist_q[STAGES-1];

endmodule

`default_nettype wire

FILE: sv/rdd_div.sv
// Pipelined rounding divider: depth = floor((dist*2^21 + t) / (2t)).
// One setup stage, then two quotient bits per stage. Uses rdd_pkg.
`default_nettype none

module rdd_div #(
  parameter int unsigned DIST_BITS = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire  [rdd_pkg::ROOT_W-1:0]   root_i,
  input  wire  [DIST_BITS-1:0]         dist_i,
  output logic                         valid_o,
  output logic [DIST_BITS-1:0]         depth_o
);

  localparam int unsigned ROOT_W = rdd_pkg::ROOT_W;
  localparam int unsigned STEPS  = rdd_pkg::DIV_STEPS;
  localparam int unsigned STAGES = (DIST_BITS + STEPS - 1) / STEPS;
  localparam int unsigned NUM_W  = DIST_BITS + rdd_pkg::FRAC_BITS + 2;
  localparam int unsigned TOP_W  = NUM_W - DIST_BITS;
  localparam int unsigned DEN_W  = ROOT_W + 1;
  localparam int unsigned REM_W  = DEN_W + 1;

  // setup stage: numerator and doubled divisor
  logic                 vs_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q;
  logic [NUM_W-1:0]     num_d;

  assign num_d = (NUM_W'(dist_i) << (rdd_pkg::FRAC_BITS + 1)) + NUM_W'(root_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (en_i) begin
      vs_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= {root_i, 1'b0};
    end
  end

  logic                 v_q   [STAGES];
  logic [REM_W-1:0]     rem_q [STAGES];
  logic [DIST_BITS-1:0] quo_q [STAGES];
  logic [DIST_BITS-1:0] low_q [STAGES];
  logic [DEN_W-1:0]     den_s [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                 v_in;
    logic [REM_W-1:0]     rem_in, rem_d;
    logic [DIST_BITS-1:0] quo_in, quo_d, low_in;
    logic [DEN_W-1:0]     den_in;

    if (k == 0) begin : g_first
      // quotient fits DIST_BITS, so the top part is already below the divisor
      assign v_in   = vs_q;
      assign rem_in = REM_W'(num_q[NUM_W-1 -: TOP_W]);
      assign quo_in = '0;
      assign low_in = num_q[DIST_BITS-1:0];
      assign den_in = den_q;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_s[k-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < STEPS; j++) begin
        if (STEPS * k + j < DIST_BITS) begin
          rem_d = {rem_d[REM_W-2:0], low_in[DIST_BITS-1-(STEPS*k+j)]};
          if (rem_d >= REM_W'(den_in)) begin
            rem_d = rem_d - REM_W'(den_in);
            quo_d = {quo_d[DIST_BITS-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[DIST_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        low_q[k] <= low_in;
        den_s[k] <= den_in;
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign depth_o = quo_q[STAGES-1];

endmodule

`default_nettype wire

FILE: sv/rdd_out.sv
// Output register plus skid register for the depth channel.
// Drives the pipeline advance enable. No package dependency.
`default_nettype none

module rdd_out #(
  parameter int unsigned DIST_BITS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pipe_valid_i,
  input  wire  [DIST_BITS-1:0] pipe_depth_i,
  output logic                 pipe_en_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [DIST_BITS-1:0] depth_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  logic [DIST_BITS-1:0] out_data_q, out_data_d;
  logic [DIST_BITS-1:0] skid_data_q, skid_data_d;

  // pipeline moves whenever the skid slot is free
  assign pipe_en_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (pipe_valid_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_data_d  = pipe_depth_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = pipe_depth_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign depth_o     = out_data_q;

endmodule

`default_nettype wire

FILE: sv/radial_distance_to_depth.sv
// Top level: radial distance to planar depth for a pinhole camera.
// Instantiates rdd_front, rdd_sqrt, rdd_div and rdd_out; uses rdd_pkg.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    distance_i, column_i, row_i
//   out      out  out_valid_o / out_ready_i  depth_o
//   cfg      in   cfg_we_i                   cfg_index_i, cfg_data_i
//
// One pixel per cycle sustained while the skid register is empty. From accept
// to depth_o valid: 4 front stages, 16 sqrt stages, 1 divider setup stage,
// ceil(DIST_BITS/2) divider stages, output reg.
// Reset clears all valid bits and loads the register defaults.
// The whole pipeline holds while the skid register is full; in_ready_o is
// that register's empty flag, so one result may wait while input still flows.
`default_nettype none

module radial_distance_to_depth #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DIST_BITS  = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [rdd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [rdd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [DIST_BITS-1:0]             distance_i,
  input  wire  [COORD_BITS-1:0]            column_i,
  input  wire  [COORD_BITS-1:0]            row_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [DIST_BITS-1:0]             depth_o
);

  rdd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_focal_x <= rdd_pkg::RST_INV_FOCAL_X;
      cfg_q.inv_focal_y <= rdd_pkg::RST_INV_FOCAL_Y;
      cfg_q.principal_x <= rdd_pkg::RST_PRINCIPAL_X;
      cfg_q.principal_y <= rdd_pkg::RST_PRINCIPAL_Y;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rdd_pkg::REG_INV_FOCAL_X: cfg_q.inv_focal_x <= cfg_data_i;
        rdd_pkg::REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= cfg_data_i;
        rdd_pkg::REG_PRINCIPAL_X: cfg_q.principal_x <= cfg_data_i[rdd_pkg::PRIN_W-1:0];
        rdd_pkg::REG_PRINCIPAL_Y: cfg_q.principal_y <= cfg_data_i[rdd_pkg::PRIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic                          en;
  logic                          sum_valid;
  logic [rdd_pkg::SUM_W-1:0]     sum;
  logic [DIST_BITS-1:0]          sum_dist;
  logic                          root_valid;
  logic [rdd_pkg::ROOT_W-1:0]    root;
  logic [DIST_BITS-1:0]          root_dist;
  logic                          div_valid;
  logic [DIST_BITS-1:0]          div_depth;

  assign in_ready_o = en;

  rdd_front #(
    .COORD_BITS (COORD_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .valid_i    (in_valid_i),
    .distance_i (distance_i),
    .column_i   (column_i),
    .row_i      (row_i),
    .valid_o    (sum_valid),
    .sum_o      (sum),
    .dist_o     (sum_dist)
  );

  rdd_sqrt #(
    .DIST_BITS (DIST_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_valid),
    .sum_i   (sum),
    .dist_i  (sum_dist),
    .valid_o (root_valid),
    .root_o  (root),
    .dist_o  (root_dist)
  );

  rdd_div #(
    .DIST_BITS (DIST_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (root_valid),
    .root_i  (root),
    .dist_i  (root_dist),
    .valid_o (div_valid),
    .depth_o (div_depth)
  );

  rdd_out #(
    .DIST_BITS (DIST_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_valid_i (div_valid),
    .pipe_depth_i (div_depth),
    .pipe_en_o    (en),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .depth_o      (depth_o)
  );

  // the skid slot only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("skid register full while output register empty");

  // back pressure persists until the sink takes a beat
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("stall released without an output beat");

  // sum of squares always carries the +1 term
  a_sum_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid |-> (sum[rdd_pkg::SUM_W-1:2*rdd_pkg::FRAC_BITS] != '0))
    else $error("sum of squares below one");

  // root of a value >= 2^40 is >= 2^20
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_valid |-> (root[rdd_pkg::ROOT_W-1:rdd_pkg::FRAC_BITS] != '0))
    else $error("root below one");

endmodule

`default_nettype wire
